[design/dual_motor_ramp_direction_interlock_macros.svh]
// Assertion macros used by the checker file.
`ifndef DUAL_MOTOR_RAMP_DIRECTION_INTERLOCK_MACROS_SVH
`define DUAL_MOTOR_RAMP_DIRECTION_INTERLOCK_MACROS_SVH

// Checked only while out of reset.
`define DMRI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DMRI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/dmri_pkg.sv]
`default_nettype none

package dmri_pkg;

  typedef enum logic [2:0] {
    MOTION_STOP     = 3'd0,
    MOTION_FORWARD  = 3'd1,
    MOTION_BACKWARD = 3'd2,
    MOTION_LEFT     = 3'd3,
    MOTION_RIGHT    = 3'd4
  } motion_e;

  typedef enum logic [1:0] {
    CFG_RAMP_STEP     = 2'd0,
    CFG_MAX_LEFT      = 2'd1,
    CFG_MAX_RIGHT     = 2'd2,
    CFG_RAMP_INTERVAL = 2'd3
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  localparam logic [7:0]  RST_RAMP_STEP     = 8'd10;
  localparam logic [7:0]  RST_MAX_SPEED     = 8'd255;
  localparam logic [15:0] RST_RAMP_INTERVAL = 16'd10;
  localparam logic [15:0] TICKS_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  ramp_step;
    logic [7:0]  max_speed_left;
    logic [7:0]  max_speed_right;
    logic [15:0] ramp_interval;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] command;
  } item_t;

  typedef struct packed {
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       fwd_left;
    logic       fwd_right;
    logic [2:0] motion_now;
  } result_t;

  // Step up, clamp to the maximum.
  function automatic logic [7:0] ramp_up(input logic [7:0] speed,
                                         input logic [7:0] step,
                                         input logic [7:0] maxv);
    logic [8:0] sum;
    sum = {1'b0, speed} + {1'b0, step};
    return (sum > {1'b0, maxv}) ? maxv : sum[7:0];
  endfunction

  // Step down to zero, then clamp to a possibly lowered maximum.
  function automatic logic [7:0] ramp_down(input logic [7:0] speed,
                                           input logic [7:0] step,
                                           input logic [7:0] maxv);
    logic [7:0] lowered;
    lowered = (speed > step) ? (speed - step) : 8'd0;
    return (lowered > maxv) ? maxv : lowered;
  endfunction

endpackage

`default_nettype wire

[design/dmri_if.sv]
`default_nettype none

interface dmri_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [2:0] command;

  modport source (output valid, mode, command, input ready);
  modport sink   (input valid, mode, command, output ready);
endinterface

interface dmri_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_left;
  logic [7:0] duty_right;
  logic       fwd_left;
  logic       fwd_right;
  logic [2:0] motion_now;

  modport source (output valid, duty_left, duty_right, fwd_left, fwd_right, motion_now,
                  input ready);
  modport sink   (input valid, duty_left, duty_right, fwd_left, fwd_right, motion_now,
                  output ready);
endinterface

`default_nettype wire

[design/dmri_cfg.sv]
`default_nettype none

module dmri_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               we_i,
  input  wire logic [dmri_pkg::CFG_IDX_W-1:0]     idx_i,
  input  wire logic [dmri_pkg::CFG_DATA_W-1:0]    data_i,
  output dmri_pkg::cfg_t                          cfg_o
);

  dmri_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (dmri_pkg::cfg_idx_e'(idx_i))
        dmri_pkg::CFG_RAMP_STEP:     cfg_d.ramp_step       = data_i[7:0];
        dmri_pkg::CFG_MAX_LEFT:      cfg_d.max_speed_left  = data_i[7:0];
        dmri_pkg::CFG_MAX_RIGHT:     cfg_d.max_speed_right = data_i[7:0];
        dmri_pkg::CFG_RAMP_INTERVAL: cfg_d.ramp_interval   = data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step       <= dmri_pkg::RST_RAMP_STEP;
      cfg_q.max_speed_left  <= dmri_pkg::RST_MAX_SPEED;
      cfg_q.max_speed_right <= dmri_pkg::RST_MAX_SPEED;
      cfg_q.ramp_interval   <= dmri_pkg::RST_RAMP_INTERVAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/dmri_core.sv]
`default_nettype none

// Motion state and its combinational update for one registered transaction.
module dmri_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire dmri_pkg::item_t     item_i,
  input  wire dmri_pkg::cfg_t      cfg_i,
  output dmri_pkg::result_t        result_o
);

  logic [7:0]        speed_left_q, speed_left_d;
  logic [7:0]        speed_right_q, speed_right_d;
  dmri_pkg::motion_e running_q, running_d;
  dmri_pkg::motion_e target_q, target_d;
  logic [15:0]       ticks_q, ticks_d;
  logic              fwd_left_q, fwd_left_d;
  logic              fwd_right_q, fwd_right_d;

  logic [15:0] ticks_inc;
  logic [7:0]  ramp_left, ramp_right;
  logic        ramp_down_sel;

  always_comb begin
    speed_left_d  = speed_left_q;
    speed_right_d = speed_right_q;
    running_d     = running_q;
    target_d      = target_q;
    ticks_d       = ticks_q;
    fwd_left_d    = fwd_left_q;
    fwd_right_d   = fwd_right_q;

    ticks_inc     = (ticks_q == dmri_pkg::TICKS_MAX) ? ticks_q : ticks_q + 16'd1;
    ramp_down_sel = (running_q == dmri_pkg::MOTION_STOP);
    ramp_left     = ramp_down_sel
                  ? dmri_pkg::ramp_down(speed_left_q, cfg_i.ramp_step, cfg_i.max_speed_left)
                  : dmri_pkg::ramp_up(speed_left_q, cfg_i.ramp_step, cfg_i.max_speed_left);
    ramp_right    = ramp_down_sel
                  ? dmri_pkg::ramp_down(speed_right_q, cfg_i.ramp_step, cfg_i.max_speed_right)
                  : dmri_pkg::ramp_up(speed_right_q, cfg_i.ramp_step, cfg_i.max_speed_right);

    if (item_i.mode == dmri_pkg::MODE_COMMAND) begin
      if (item_i.command == dmri_pkg::MOTION_STOP) begin
        running_d = dmri_pkg::MOTION_STOP;
        target_d  = dmri_pkg::MOTION_STOP;
      end else if (item_i.command <= dmri_pkg::MOTION_RIGHT) begin
        // Drop to stop on any change so the motors ramp down first.
        if (running_q != dmri_pkg::motion_e'(item_i.command)) begin
          running_d = dmri_pkg::MOTION_STOP;
        end
        target_d = dmri_pkg::motion_e'(item_i.command);
      end
    end else begin
      ticks_d = ticks_inc;
      if (ticks_inc > cfg_i.ramp_interval) begin
        ticks_d       = 16'd0;
        speed_left_d  = ramp_left;
        speed_right_d = ramp_right;
        // Interlock: take the target only at standstill.
        if (ramp_left == 8'd0 && ramp_right == 8'd0) begin
          running_d = target_q;
          case (target_q)
            dmri_pkg::MOTION_FORWARD: begin
              fwd_left_d  = 1'b1;
              fwd_right_d = 1'b1;
            end
            dmri_pkg::MOTION_BACKWARD: begin
              fwd_left_d  = 1'b0;
              fwd_right_d = 1'b0;
            end
            dmri_pkg::MOTION_LEFT: begin
              fwd_left_d  = 1'b1;
              fwd_right_d = 1'b0;
            end
            dmri_pkg::MOTION_RIGHT: begin
              fwd_left_d  = 1'b0;
              fwd_right_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_left_q  <= 8'd0;
      speed_right_q <= 8'd0;
      running_q     <= dmri_pkg::MOTION_STOP;
      target_q      <= dmri_pkg::MOTION_STOP;
      ticks_q       <= 16'd0;
      fwd_left_q    <= 1'b0;
      fwd_right_q   <= 1'b0;
    end else if (advance_i) begin
      speed_left_q  <= speed_left_d;
      speed_right_q <= speed_right_d;
      running_q     <= running_d;
      target_q      <= target_d;
      ticks_q       <= ticks_d;
      fwd_left_q    <= fwd_left_d;
      fwd_right_q   <= fwd_right_d;
    end
  end

  assign result_o.duty_left  = speed_left_d;
  assign result_o.duty_right = speed_right_d;
  assign result_o.fwd_left   = fwd_left_d;
  assign result_o.fwd_right  = fwd_right_d;
  assign result_o.motion_now = running_d;

endmodule

`default_nettype wire

[design/dual_motor_ramp_direction_interlock.sv]
// Dual motor soft-start ramp with a direction-change interlock.
// in_i carries one transaction per tick or motion command: mode 0 is a one
// millisecond tick, mode 1 a command (stop, forward, backward, left, right).
// out_o returns exactly one transaction per input transaction with both PWM
// duties, both direction bits and the running motion after the update.
// Configuration (ramp step, two maxima, ramp interval) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while no
// transaction is in flight; the block itself does not enforce this.
// An accepted transaction is registered in item_q, its state update is
// combinational and the result is registered in result_q on advance.
// Throughput: one transaction per cycle unless the receiver stalls; the
// update is a single combinational step between input and result register.
// On a stall the result register holds, the input register takes one more
// transaction if empty, then in_i.ready drops until out_o.ready returns.
// Reset clears speeds, motions, tick count and direction bits to zero (stop)
// and loads the register defaults: step 10, maxima 255, interval 10.
`default_nettype none

module dual_motor_ramp_direction_interlock (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  dmri_item_if.sink                              in_i,
  dmri_result_if.source                          out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dmri_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [dmri_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  dmri_pkg::cfg_t    cfg;
  dmri_pkg::item_t   item_q;
  dmri_pkg::result_t result_d, result_q;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_accept;

  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  dmri_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  dmri_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.mode    <= in_i.mode;
      item_q.command <= in_i.command;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.duty_left  = result_q.duty_left;
  assign out_o.duty_right = result_q.duty_right;
  assign out_o.fwd_left   = result_q.fwd_left;
  assign out_o.fwd_right  = result_q.fwd_right;
  assign out_o.motion_now = result_q.motion_now;

endmodule

`default_nettype wire

[design/dmri_checker.sv]
`default_nettype none

`include "dual_motor_ramp_direction_interlock_macros.svh"

module dmri_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] duty_left,
  input wire logic [7:0] duty_right,
  input wire logic       fwd_left,
  input wire logic       fwd_right,
  input wire logic [2:0] motion_now
);

  `DMRI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `DMRI_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(duty_left) && $stable(duty_right) && $stable(fwd_left) && $stable(fwd_right) && $stable(motion_now), "stalled result changed")
  `DMRI_ASSERT(a_in_backpressure, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")
  `DMRI_ASSERT(a_forward_dirs, out_valid && motion_now == dmri_pkg::MOTION_FORWARD |-> fwd_left && fwd_right, "forward motion with wrong direction bits")
  `DMRI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid, "result valid straight after reset")

endmodule

bind dual_motor_ramp_direction_interlock dmri_checker u_dmri_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .duty_left  (out_o.duty_left),
  .duty_right (out_o.duty_right),
  .fwd_left   (out_o.fwd_left),
  .fwd_right  (out_o.fwd_right),
  .motion_now (out_o.motion_now)
);

`default_nettype wire
